### src/brfifo_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brfifo_pkg: shared types and codes for the byte ring FIFO
// Request and response payloads, the decoded command that passes from the
// front end to the back end, and the item kind codes.
// ----------------------------------------------------------------------------
package brfifo_pkg;

  localparam int KIND_W  = 2;
  localparam int BYTE_W  = 8;
  localparam int COUNT_W = 7;
  localparam int LEVEL_W = 11;

  // Item kind codes as they arrive on the request channel
  localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FLUSH = 2'd2;

  // Decoded operation carried through the command queue
  typedef enum logic [1:0] {
    OP_WRITE,
    OP_READ,
    OP_FLUSH,
    OP_NOP
  } op_t;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [BYTE_W-1:0]  data_byte;
    logic [COUNT_W-1:0] read_count;
    logic               consume;
    logic               deliver;
  } req_t;

  typedef struct packed {
    logic [BYTE_W-1:0]  out_byte;
    logic               status;
    logic [COUNT_W-1:0] moved;
    logic               last;
    logic [LEVEL_W-1:0] readable;
    logic [LEVEL_W-1:0] writable;
  } rsp_t;

  typedef struct packed {
    op_t                op;
    logic [BYTE_W-1:0]  data_byte;
    logic [COUNT_W-1:0] count;
    logic               consume;
    logic               deliver;
  } cmd_t;

endpackage

### src/brfifo_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brfifo_front: request classifier
// Decodes the item kind into an operation and saturates the read count to
// the burst limit before the command enters the queue.
// ----------------------------------------------------------------------------
module brfifo_front
  import brfifo_pkg::*;
#(
  parameter int MAX_BURST = 64
) (
  input  req_t req,
  output cmd_t cmd
);

  localparam logic [COUNT_W-1:0] BURST_LIM = COUNT_W'(MAX_BURST);

  // Classify the item kind; the unused code becomes a no-op.
  // Saturate the requested count and pass the rest through.
  always_comb begin
    cmd.data_byte = req.data_byte;
    cmd.count     = (req.read_count > BURST_LIM) ? BURST_LIM : req.read_count;
    cmd.consume   = req.consume;
    cmd.deliver   = req.deliver;
    case (req.kind)
      KIND_WRITE: cmd.op = OP_WRITE;
      KIND_READ:  cmd.op = OP_READ;
      KIND_FLUSH: cmd.op = OP_FLUSH;
      default:    cmd.op = OP_NOP;
    endcase
  end

endmodule

### src/brfifo_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brfifo_queue: two-entry command queue
// Decouples the request channel from the back end so that either side can
// stall without holding up the other.
// ----------------------------------------------------------------------------
module brfifo_queue
  import brfifo_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic push_ready,
  input  cmd_t push_cmd,
  output logic head_valid,
  input  logic pop,
  output cmd_t head_cmd
);

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign push_ready = (count != 2'd2);
  assign head_valid = (count != 2'd0);
  assign head_cmd   = slots[rd_ptr];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // Hold the command payloads
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_cmd;
  end

endmodule

### src/brfifo_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brfifo_back: FIFO execution engine
// Owns the byte memory and the wrap-bit pointers, executes one command at a
// time and streams delivered bytes through a registered read stage.
// ----------------------------------------------------------------------------
module brfifo_back
  import brfifo_pkg::*;
#(
  parameter int CAP_LOG2 = 10
) (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  output logic cmd_pop,
  input  cmd_t cmd,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  localparam int PTR_W = CAP_LOG2 + 1;
  localparam logic [PTR_W-1:0] CAP = {1'b1, {CAP_LOG2{1'b0}}};

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_READ = 2'b10
  } state_t;

  logic [BYTE_W-1:0]   mem [2**CAP_LOG2];

  state_t              state;
  logic [PTR_W-1:0]    wp;
  logic [PTR_W-1:0]    rp;
  logic                rd_pend;
  logic                rd_fin;
  logic [BYTE_W-1:0]   rd_data;
  logic [CAP_LOG2-1:0] rd_addr;
  logic [COUNT_W-1:0]  rem;
  logic [COUNT_W-1:0]  n_hold;
  logic [LEVEL_W-1:0]  hold_readable;
  logic [LEVEL_W-1:0]  hold_writable;

  logic [PTR_W-1:0]    fill;
  logic [PTR_W-1:0]    fill_after;
  logic                full;
  logic                empty;
  logic [COUNT_W-1:0]  n;
  logic                out_free;
  logic                start;
  logic                go_read;
  logic                issue;
  logic                load_rd;
  logic                mem_we;
  logic [LEVEL_W-1:0]  readable_after;
  logic [LEVEL_W-1:0]  writable_after;
  rsp_t                summary;

  // Fill level and burst length
  assign fill  = wp - rp;
  assign full  = (fill == CAP);
  assign empty = (fill == '0);
  assign n     = (32'(cmd.count) <= 32'(fill)) ? cmd.count : COUNT_W'(fill);

  // Fill left behind by the command at the head
  always_comb begin
    case (cmd.op)
      OP_WRITE: fill_after = full ? fill : fill + PTR_W'(1);
      OP_READ:  fill_after = cmd.consume ? fill - PTR_W'(n) : fill;
      OP_FLUSH: fill_after = '0;
      default:  fill_after = fill;
    endcase
  end

  assign readable_after = LEVEL_W'(fill_after);
  assign writable_after = LEVEL_W'(CAP - fill_after);

  // Handshake between command queue, read stage and response register
  assign out_free = !rsp_valid || rsp_ready;
  assign start    = (state == ST_IDLE) && !rd_pend && cmd_valid && out_free;
  assign cmd_pop  = start;
  assign go_read  = start && (cmd.op == OP_READ) && !empty && (n != '0) && cmd.deliver;
  assign load_rd  = rd_pend && out_free;
  assign issue    = (state == ST_READ) && (!rd_pend || out_free);
  assign mem_we   = start && (cmd.op == OP_WRITE) && !full;

  // Single-result response for every command but a delivered read
  always_comb begin
    summary          = '0;
    summary.last     = 1'b1;
    summary.readable = readable_after;
    summary.writable = writable_after;
    case (cmd.op)
      OP_WRITE: begin
        summary.status = full;
        summary.moved  = full ? '0 : COUNT_W'(1);
      end
      OP_READ: begin
        summary.status = empty;
        summary.moved  = n;
      end
      default: begin
        summary.status = 1'b0;
        summary.moved  = '0;
      end
    endcase
  end

  // Control state: pointers, sequencer, read stage and response valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      wp        <= '0;
      rp        <= '0;
      rd_pend   <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (start) begin
        case (cmd.op)
          OP_WRITE: if (!full) wp <= wp + PTR_W'(1);
          OP_READ:  if (cmd.consume) rp <= rp + PTR_W'(n);
          OP_FLUSH: begin
            wp <= '0;
            rp <= '0;
          end
          default: ;
        endcase
      end

      if (go_read) begin
        state <= ST_READ;
      end else if (issue && rem == COUNT_W'(1)) begin
        state <= ST_IDLE;
      end

      if (issue) begin
        rd_pend <= 1'b1;
      end else if (load_rd) begin
        rd_pend <= 1'b0;
      end

      if ((start && !go_read) || load_rd) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Burst bookkeeping, held for the length of a delivered read
  always_ff @(posedge clk) begin
    if (go_read) begin
      rem           <= n;
      rd_addr       <= rp[CAP_LOG2-1:0];
      n_hold        <= n;
      hold_readable <= readable_after;
      hold_writable <= writable_after;
    end else if (issue) begin
      rem     <= rem - COUNT_W'(1);
      rd_addr <= rd_addr + CAP_LOG2'(1);
    end
    if (issue) rd_fin <= (rem == COUNT_W'(1));
  end

  // Byte memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) mem[wp[CAP_LOG2-1:0]] <= cmd.data_byte;
    if (issue)  rd_data <= mem[rd_addr];
  end

  // Response payload
  always_ff @(posedge clk) begin
    if (start && !go_read) begin
      rsp <= summary;
    end else if (load_rd) begin
      rsp.out_byte <= rd_data;
      rsp.status   <= 1'b0;
      rsp.moved    <= rd_fin ? n_hold : '0;
      rsp.last     <= rd_fin;
      rsp.readable <= hold_readable;
      rsp.writable <= hold_writable;
    end
  end

endmodule

### src/byte_ring_fifo_peek.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_ring_fifo_peek: byte ring FIFO with peek, skip and flush
// Requests are classified by the front end, queued, and executed by the
// back end over a 2**CAP_LOG2 byte memory with wrap-bit pointers.
//
//   channel  | valid     | ready     | payload
//   ---------+-----------+-----------+---------------------------------
//   request  | req_valid | req_ready | req (kind, byte, count, flags)
//   response | rsp_valid | rsp_ready | rsp (byte, status, levels)
//
// Write, flush, blocked and summary reads each give a single result.
// Delivered read of n bytes: one byte per cycle while rsp_ready stays high,
// set by the single registered read port of the byte memory.
// Each request is registered in the command queue on its transfer; the
// two-entry command queue absorbs up to two requests while the back end is
// busy, after which req_ready drops until the back end takes one.
// Reset clears the pointers and queue; memory contents are not cleared.
// A stalled response holds the back end, never the request side directly.
// ----------------------------------------------------------------------------
module byte_ring_fifo_peek
  import brfifo_pkg::*;
#(
  parameter int CAP_LOG2  = 10,
  parameter int MAX_BURST = 64
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  cmd_t front_cmd;
  cmd_t head_cmd;
  logic head_valid;
  logic head_pop;

  // Classify the incoming request
  brfifo_front #(
    .MAX_BURST(MAX_BURST)
  ) u_front (
    .req(req),
    .cmd(front_cmd)
  );

  // Queue commands between front and back
  brfifo_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (req_valid && req_ready),
    .push_ready(req_ready),
    .push_cmd  (front_cmd),
    .head_valid(head_valid),
    .pop       (head_pop),
    .head_cmd  (head_cmd)
  );

  // Execute against the byte memory
  brfifo_back #(
    .CAP_LOG2(CAP_LOG2)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(head_valid),
    .cmd_pop  (head_pop),
    .cmd      (head_cmd),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

endmodule

### src/brfifo_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brfifo_checker: port-level checks for the byte ring FIFO
// Watches the response channel for level consistency and result framing.
// ----------------------------------------------------------------------------
module brfifo_checker
  import brfifo_pkg::*;
#(
  parameter int CAP_LOG2 = 10
) (
  input logic clk,
  input logic rst,
  input logic rsp_valid,
  input logic rsp_ready,
  input rsp_t rsp
);

  localparam logic [LEVEL_W-1:0] CAP_LVL = LEVEL_W'(2 ** CAP_LOG2);

  // Hold a stalled response
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("response dropped or changed while stalled");

  // Readable and writable always add up to the capacity
  a_levels: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.readable + rsp.writable) == CAP_LVL)
    else $error("readable plus writable differs from capacity");

  // A blocked transfer is a single, empty result
  a_block: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status |-> rsp.last && rsp.moved == '0 && rsp.out_byte == '0)
    else $error("would-block result is not a lone empty result");

  // Only the final result of a burst carries the moved count
  a_mid_burst: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.last |-> rsp.moved == '0 && !rsp.status)
    else $error("mid-burst result carries count or status");

  // No response straight out of reset
  a_reset: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid after reset");

endmodule

bind byte_ring_fifo_peek brfifo_checker #(
  .CAP_LOG2(CAP_LOG2)
) u_checker (.*);
